>>> design/sem_pkg.sv
package sem_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW = 10;
  localparam int RowW = 12;
  localparam int WidthRegW = 11;
  localparam int HeightRegW = 13;
  localparam int CfgW = 13;
  localparam logic [0:0] RegImageWidth = 1'b0;
  localparam logic [0:0] RegImageHeight = 1'b1;

  // window handed from front to back
  typedef struct packed {
    logic [7:0] t0, m0, b0;   // column c-2
    logic [7:0] t1, m1, b1;   // column c-1
    logic [7:0] t2, m2, b2;   // column c
    logic       last;
  } win_t;

  typedef struct packed {
    logic [7:0] x_gradient;
    logic [7:0] y_gradient;
    logic [7:0] magnitude;
    logic       last_of_frame;
  } res_t;
endpackage

>>> design/sem_ram.sv
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/sem_front.sv
module sem_front import sem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [WidthRegW-1:0]  image_width,
  input  logic [HeightRegW-1:0] image_height,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            pixel,
  input  logic                  sof,
  output logic                  win_valid,
  input  logic                  win_ready,
  output win_t                  win
);
  // each pixel passes through S_READ, which issues the line-store read, then S_EXEC, which uses the data
  typedef enum logic [1:0] {S_READ = 2'b01, S_EXEC = 2'b10} st_t;
  st_t state;
  logic [ColW-1:0] column_position;
  logic [RowW-1:0] row_position;
  logic            col_wrap;      // next column already at/over width
  logic [7:0]      pix_q;
  logic            sof_q;
  logic [7:0]      wc [6];
  logic [7:0]      top, mid;
  logic [ColW:0]   w_eff;
  logic [RowW:0]   h_eff;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic            last, produce;

  always_comb begin
    if (image_width < WidthRegW'(3)) w_eff = (ColW+1)'(3);
    else if (image_width > WidthRegW'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
    else w_eff = image_width[ColW:0];
    if (image_height < HeightRegW'(3)) h_eff = (RowW+1)'(3);
    else if (image_height > HeightRegW'(MaxHeight)) h_eff = (RowW+1)'(MaxHeight);
    else h_eff = image_height[RowW:0];
  end

  // position resolution, same order as the pixel arrives
  always_comb begin
    logic [ColW:0] c1;
    logic [RowW:0] r1;
    c1 = {1'b0, column_position};
    r1 = {1'b0, row_position};
    if (sof_q) begin
      c1 = '0; r1 = '0;
    end
    if (col_wrap && !sof_q) begin
      c1 = '0; r1 = r1 + 1'b1;
    end else if (!sof_q && c1 >= w_eff) begin
      c1 = '0; r1 = r1 + 1'b1;
    end
    if (r1 >= h_eff) r1 = '0;
    col = c1[ColW-1:0];
    row = r1[RowW-1:0];
  end

  assign last    = ({1'b0, row} == h_eff - 1'b1) && ({1'b0, col} == w_eff - 1'b1);
  assign produce = (row >= RowW'(2)) && (col >= ColW'(2));
  assign in_ready = (state == S_READ);

  // read address: incoming pixel position while idle, held at the resolved
  // column while executing so a stall re-reads the same entry
  logic [ColW-1:0] rd_col;
  always_comb begin
    rd_col = column_position;
    if (state == S_EXEC) rd_col = col;
    else if (sof || {1'b0, column_position} >= w_eff || col_wrap) rd_col = '0;
  end

  logic exec_go;
  assign exec_go = (state == S_EXEC) && (!produce || win_ready);

  sem_ram #(.Width(8), .Depth(MaxWidth)) u_upper (
    .clk(clk), .we(exec_go), .waddr(col), .wdata(mid), .raddr(rd_col), .rdata(top));
  sem_ram #(.Width(8), .Depth(MaxWidth)) u_middle (
    .clk(clk), .we(exec_go), .waddr(col), .wdata(pix_q), .raddr(rd_col), .rdata(mid));

  assign win_valid = (state == S_EXEC) && produce;
  always_comb begin
    win.t0 = wc[0]; win.m0 = wc[1]; win.b0 = wc[2];
    win.t1 = wc[3]; win.m1 = wc[4]; win.b1 = wc[5];
    win.t2 = top;   win.m2 = mid;   win.b2 = pix_q;
    win.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READ;
      column_position <= '0;
      row_position <= '0;
      col_wrap <= 1'b0;
      for (int i = 0; i < 6; i++) wc[i] <= '0;
    end else begin
      case (state)
        S_READ: begin
          if (in_valid) begin
            pix_q <= pixel;
            sof_q <= sof;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            wc[0] <= wc[3]; wc[1] <= wc[4]; wc[2] <= wc[5];
            wc[3] <= top;   wc[4] <= mid;   wc[5] <= pix_q;
            col_wrap <= 1'b0;
            if (last) begin
              column_position <= '0; row_position <= '0;
            end else if ({1'b0, col} + 1'b1 >= w_eff) begin
              column_position <= col;
              row_position <= row;
              col_wrap <= 1'b1;
            end else begin
              column_position <= col + 1'b1;
              row_position <= row;
            end
            state <= S_READ;
          end
        end
        default: state <= S_READ;
      endcase
    end
  end
endmodule

>>> design/sem_queue.sv
module sem_queue import sem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  win_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output win_t out_data
);
  win_t q [2];
  logic [1:0] cnt;
  logic       rp, wp;
  logic       push, pop;
  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = q[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (push) q[wp] <= in_data;
    if (rst) begin
      cnt <= '0; rp <= 1'b0; wp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> design/sem_back.sv
module sem_back import sem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic win_valid,
  output logic win_ready,
  input  win_t win,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  // stage 1: gradients; 2: squares; 8-step root 1 bit/cycle, last waits
  typedef enum logic [2:0] {B_IDLE = 3'b001, B_SQ = 3'b010, B_ROOT = 3'b100} st_t;
  st_t state;
  logic [9:0]  ax, ay;
  logic [15:0] rem;
  logic [7:0]  root;
  logic [2:0]  step;
  logic        last;
  logic        out_full;
  logic        fire;
  logic signed [11:0] gx, gy;

  always_comb begin
    gx = 12'(signed'({4'b0, win.t2})) - 12'(signed'({4'b0, win.t0}))
       + 12'(signed'({3'b0, win.m2, 1'b0})) - 12'(signed'({3'b0, win.m0, 1'b0}))
       + 12'(signed'({4'b0, win.b2})) - 12'(signed'({4'b0, win.b0}));
    gy = 12'(signed'({4'b0, win.b0})) - 12'(signed'({4'b0, win.t0}))
       + 12'(signed'({3'b0, win.b1, 1'b0})) - 12'(signed'({3'b0, win.t1, 1'b0}))
       + 12'(signed'({4'b0, win.b2})) - 12'(signed'({4'b0, win.t2}));
  end

  assign win_ready = (state == B_IDLE);
  assign res_valid = out_full;
  // last root step may complete once the output register is free
  assign fire = (state == B_ROOT) && (step == 3'd0) && (!out_full || res_ready);

  logic [15:0] trial;
  logic [7:0]  cand;
  always_comb begin
    cand  = root | (8'd1 << step);
    trial = 16'(cand) * 16'(cand);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_full <= 1'b0;
    end else begin
      if (fire) out_full <= 1'b1;
      else if (res_ready) out_full <= 1'b0;
      case (state)
        B_IDLE: begin
          if (win_valid) begin
            ax <= gx[11] ? 10'(-gx) : gx[9:0];
            ay <= gy[11] ? 10'(-gy) : gy[9:0];
            last <= win.last;
            state <= B_SQ;
          end
        end
        B_SQ: begin
          rem  <= 16'(({11'b0, ax} * {11'b0, ax} + {11'b0, ay} * {11'b0, ay}) >> 5);
          root <= '0;
          step <= 3'd7;
          state <= B_ROOT;
        end
        B_ROOT: begin
          if (step != 3'd0 || fire) begin
            logic [7:0] nr;
            nr = (trial <= rem) ? cand : root;
            root <= nr;
            if (step == 3'd0) begin
              res.x_gradient <= ax[9:2];
              res.y_gradient <= ay[9:2];
              res.magnitude <= nr;
              res.last_of_frame <= last;
              state <= B_IDLE;
            end else step <= step - 1'b1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

>>> design/sobel_edge_magnitude.sv
// Sobel 3x3 edge detector on an 8-bit raster stream. Each pixel transaction
// on s_axis (tdata = pixel, tuser = start_of_frame) passes through a read
// state, which issues the registered line-store read, then an execute state
// in the front end; pixels in the first two rows or columns yield nothing.
// Interior results (|gx|/4, |gy|/4, root of (gx^2+gy^2)/32, tlast on the last
// interior pixel) become valid on m_axis after front execute, the two-entry
// queue, gradients, squares and a bit-per-cycle square root whose last bit
// waits for a free output register. The back end takes no new window until
// its result is registered, so long runs of interior pixels are throttled to
// its pace once the queue fills. image_width (reg 0) and image_height (reg 1)
// must be written by the user only when idle; the block does not enforce it.
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CfgW-1:0]  cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
  input  logic             s_axis_tuser,   // [0] start_of_frame
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] x, [15:8] y, [23:16] magnitude
  output logic             m_axis_tlast    // last_of_frame
);
  logic [WidthRegW-1:0]  image_width;
  logic [HeightRegW-1:0] image_height;
  logic fw_valid, fw_ready, bw_valid, bw_ready;
  win_t fw, bw;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WidthRegW'(640);
      image_height <= HeightRegW'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        RegImageWidth:  image_width  <= cfg_data[WidthRegW-1:0];
        RegImageHeight: image_height <= cfg_data[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  sem_front u_front (
    .clk(clk), .rst(rst), .image_width(image_width), .image_height(image_height),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .pixel(s_axis_tdata),
    .sof(s_axis_tuser), .win_valid(fw_valid), .win_ready(fw_ready), .win(fw));

  sem_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw),
    .out_valid(bw_valid), .out_ready(bw_ready), .out_data(bw));

  sem_back u_back (
    .clk(clk), .rst(rst), .win_valid(bw_valid), .win_ready(bw_ready), .win(bw),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res));

  assign m_axis_tdata = {res.magnitude, res.y_gradient, res.x_gradient};
  assign m_axis_tlast = res.last_of_frame;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_win_drop: assert property (@(posedge clk) disable iff (rst)
    fw_valid && !fw_ready |=> fw_valid)
    else $error("window lost at queue");
endmodule

>>> sim/tb_top.sv
// Self-checking bench for sobel_edge_magnitude.
// A scoreboard class mirrors the line stores, the 3x3 window and the
// row/column counters, and queues one expected result per interior pixel.
// Tasks drive pixel transactions in bursts, write image_width/image_height
// between phases (block idle), and a random backpressure pattern is applied
// on the result side.

class sobel_scoreboard;
  int unsigned width_reg  = 640;
  int unsigned height_reg = 480;
  byte unsigned upper_line[sem_pkg::MaxWidth];
  byte unsigned middle_line[sem_pkg::MaxWidth];
  byte unsigned window[6];          // c-2: top,mid,bot ; c-1: top,mid,bot
  int unsigned col, row;
  sem_pkg::res_t edge_q[$];         // expected edge results, oldest first
  int unsigned mismatches, results_seen, frames_seen, pixels_seen;

  function void write_reg(logic [0:0] idx, logic [sem_pkg::CfgW-1:0] value);
    if (idx == sem_pkg::RegImageWidth) width_reg = value & 13'h7ff;
    else                               height_reg = value & 13'h1fff;
  endfunction

  // integer square root, result fits in 8 bits
  function int unsigned root8(int unsigned v);
    int unsigned res, trial;
    res = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = res | (1 << b);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  function void note_pixel(byte unsigned pix, bit sof);
    int unsigned w, h, c, r;
    int ax, ay, gx, gy;
    byte unsigned top, mid;
    bit last;
    sem_pkg::res_t exp_res;
    w = width_reg < 3 ? 3 : (width_reg > sem_pkg::MaxWidth ? sem_pkg::MaxWidth : width_reg);
    h = height_reg < 3 ? 3 :
        (height_reg > sem_pkg::MaxHeight ? sem_pkg::MaxHeight : height_reg);
    pixels_seen++;
    if (sof) begin
      col = 0;
      row = 0;
    end
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    c = col;
    r = row;
    top = upper_line[c];
    mid = middle_line[c];
    last = (r == h - 1) && (c == w - 1);
    if (r >= 2 && c >= 2) begin
      gx = (int'(top) - int'(window[0])) + 2 * (int'(mid) - int'(window[1]))
         + (int'(pix) - int'(window[2]));
      gy = (int'(window[2]) - int'(window[0])) + 2 * (int'(window[5]) - int'(window[3]))
         + (int'(pix) - int'(top));
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      exp_res.x_gradient    = 8'(ax >> 2);
      exp_res.y_gradient    = 8'(ay >> 2);
      exp_res.magnitude     = 8'(root8((ax * ax + ay * ay) >> 5));
      exp_res.last_of_frame = last;
      edge_q.push_back(exp_res);
    end
    upper_line[c]  = mid;
    middle_line[c] = pix;
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = top;
    window[4] = mid;
    window[5] = pix;
    if (last) begin
      col = 0;
      row = 0;
    end else if (c + 1 >= w) begin
      col = 0;
      row = r + 1;
    end else begin
      col = c + 1;
    end
  endfunction

  function void check_result(sem_pkg::res_t got);
    sem_pkg::res_t exp_res;
    results_seen++;
    if (got.last_of_frame) frames_seen++;
    if (edge_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result x=%0d y=%0d mag=%0d last=%0d", got.x_gradient,
                 got.y_gradient, got.magnitude, got.last_of_frame);
      return;
    end
    exp_res = edge_q.pop_front();
    if (got !== exp_res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: exp x=%0d y=%0d mag=%0d last=%0d, got x=%0d y=%0d mag=%0d last=%0d",
                 results_seen, exp_res.x_gradient, exp_res.y_gradient, exp_res.magnitude,
                 exp_res.last_of_frame, got.x_gradient, got.y_gradient, got.magnitude,
                 got.last_of_frame);
    end
  endfunction
endclass

module tb_top;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 40;
  localparam int IdleLimit   = 3000;  // cycles without any transaction

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = RegImageWidth;
  logic [CfgW-1:0]  cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [7:0] pixel
  logic             s_axis_tuser = 1'b0; // [0] start_of_frame
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;        // [7:0] x, [15:8] y, [23:16] magnitude
  logic             m_axis_tlast;        // last_of_frame

  sobel_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned cfg_writes;
  int unsigned rx_cycle, rx_period, rx_hold;
  bit          rx_stall_on;

  sobel_edge_magnitude u_top (.*);

  always #1 clk = ~clk;

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk) begin
    sem_pkg::res_t got;
    if (!rst) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_pixel(s_axis_tdata, s_axis_tuser);
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x_gradient    = m_axis_tdata[7:0];
        got.y_gradient    = m_axis_tdata[15:8];
        got.magnitude     = m_axis_tdata[23:16];
        got.last_of_frame = m_axis_tlast;
        sb.check_result(got);
        idle_cycles = 0;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // result-side backpressure: periodic stall pattern, reshuffled now and then,
  // with stretches of no stall at all
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) begin
      rx_stall_on = $urandom_range(0, 3) != 0;
      rx_period   = $urandom_range(2, 9);
      rx_hold     = $urandom_range(1, rx_period - 1);
    end
    if (rx_stall_on) m_axis_tready = (rx_cycle % rx_period) >= rx_hold;
    else             m_axis_tready = 1'b1;
  end

  function automatic byte unsigned rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel transaction; entered and left on a falling edge
  task automatic send_pixel(byte unsigned pix, bit sof);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pix;
    s_axis_tuser  = sof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // sender pauses until every expected result is out, then lets the tail settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.edge_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, int unsigned value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CfgW'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, CfgW'(value));
    cfg_writes++;
  endtask

  // new geometry, then n pixels; first carries start_of_frame so the line
  // stores are rewritten before any expected result depends on them
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned n);
    write_cfg(RegImageWidth, w);
    write_cfg(RegImageHeight, h);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 199) == 0);
    drain();
  endtask

  initial begin
    int unsigned w, h;
    burst_left  = 0;
    rx_cycle    = 0;
    rx_period   = 4;
    rx_hold     = 1;
    rx_stall_on = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset geometry (640 wide): one partial first line, border only
    for (int i = 0; i < 10; i++) send_pixel(rand_pixel(), i == 0);
    drain();

    // 3x3 frames: max positive gx, then negative gx/gy via frame wrap
    write_cfg(RegImageWidth, 3);
    write_cfg(RegImageHeight, 3);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 3 == 0 || i < 3) ? 8'd255 : 8'd0, 1'b0);
    // restart mid-frame, all-white frame
    send_pixel(8'd17, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
    drain();

    // clamped tiny geometry (width 0 and height 2 both act as 3)
    run_phase(0, 2, 20);
    // width value above range clamps to 1024: long first line, no early wrap
    run_phase(2047, 3, 120);
    // height above range and at maximum, narrow lines
    run_phase(3, 8191, 60);
    run_phase(4, MaxHeight, 45);

    // random geometries, mostly small so frames wrap often
    for (int p = 0; p < 9; p++) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      h = $urandom_range(0, 9);
      run_phase(w, h, $urandom_range(40, 110));
    end

    $display("covered %0d pixels, %0d edge results, %0d frame ends, %0d register writes",
             sb.pixels_seen, sb.results_seen, sb.frames_seen, cfg_writes);
    if (sb.mismatches == 0 && sb.edge_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule
